/* hdl/slx_pkg.sv */
// Shared types, result kinds and helpers for the script lexer
package slx_pkg;

  // Result kinds
  localparam logic [2:0] KIND_NUM  = 3'd0;
  localparam logic [2:0] KIND_STR  = 3'd1;
  localparam logic [2:0] KIND_NAME = 3'd2;
  localparam logic [2:0] KIND_GLOB = 3'd3;
  localparam logic [2:0] KIND_MARK = 3'd4;
  localparam logic [2:0] KIND_SIGN = 3'd5;
  localparam logic [2:0] KIND_ERR  = 3'd6;
  localparam logic [2:0] KIND_END  = 3'd7;

  // Keyword codes
  localparam logic [2:0] KW_NONE   = 3'd0;
  localparam logic [2:0] KW_DEF    = 3'd1;
  localparam logic [2:0] KW_RETURN = 3'd2;
  localparam logic [2:0] KW_IF     = 3'd3;
  localparam logic [2:0] KW_ELSE   = 3'd4;
  localparam logic [2:0] KW_WHILE  = 3'd5;
  localparam logic [2:0] KW_NULL   = 3'd6;

  localparam int unsigned MaxResults = 4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_out;
    logic [7:0] second_char;
    logic       has_char;
    logic       token_first;
    logic       token_last;
    logic [2:0] keyword;
    logic       run_last;
  } out_word_t;

  // Build one result word, run_last cleared
  function automatic out_word_t mk_word(logic [2:0] kind, logic [7:0] ch, logic [7:0] ch2,
                                        logic has, logic fst, logic lst, logic [2:0] kw);
    out_word_t w;
    w.kind        = kind;
    w.char_out    = ch;
    w.second_char = ch2;
    w.has_char    = has;
    w.token_first = fst;
    w.token_last  = lst;
    w.keyword     = kw;
    w.run_last    = 1'b0;
    return w;
  endfunction

  // Keyword match on the saturated length and the last six characters
  function automatic logic [2:0] kw_of(logic [2:0] len, logic [47:0] pfx);
    logic [2:0] k;
    k = KW_NONE;
    if (len == 3'd3 && pfx == 48'h646566)        k = KW_DEF;
    if (len == 3'd6 && pfx == 48'h72657475726E)  k = KW_RETURN;
    if (len == 3'd2 && pfx == 48'h6966)          k = KW_IF;
    if (len == 3'd4 && pfx == 48'h656C7365)      k = KW_ELSE;
    if (len == 3'd5 && pfx == 48'h7768696C65)    k = KW_WHILE;
    if (len == 3'd4 && pfx == 48'h6E756C6C)      k = KW_NULL;
    return k;
  endfunction

endpackage

/* hdl/script_lexer_with_sign_folding.sv */
// Streaming script lexer with sign folding: top level
//
// One ASCII character enters per input word (in_word_i, with a last flag that
// closes the source text). Each character yields zero to four result words on
// the output channel, in order, each carrying run_last on the final one.
// Both channels use valid/stall: a word moves on a rising edge where valid is
// high and stall is low.
// The lexer state and all result words of a character are worked out
// combinationally from the input word and latched into a four-deep result
// buffer; the first result appears on the output in the cycle after the input
// is taken. Throughput: one character per cycle while each yields at most one
// result and the receiver does not stall; the buffer drains one word per cycle
// while not stalled. The input is stalled while the buffer still holds more
// than one word, or one word that the receiver is stalling.
// Reset (asynchronous, active low) empties the buffer and puts the lexer
// between tokens. A stalled output word holds steady until taken.
// After a last character all lexer state returns to its reset values.
module script_lexer_with_sign_folding (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  slx_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output slx_pkg::out_word_t   out_word_o
);

  localparam logic [3:0] MODE_IDLE = 4'd0;
  localparam logic [3:0] MODE_NUM  = 4'd1;
  localparam logic [3:0] MODE_STR  = 4'd2;
  localparam logic [3:0] MODE_ESC  = 4'd3;
  localparam logic [3:0] MODE_NAME = 4'd4;
  localparam logic [3:0] MODE_GLOB = 4'd5;
  localparam logic [3:0] MODE_MARK = 4'd6;
  localparam logic [3:0] MODE_CMT  = 4'd7;
  localparam logic [3:0] MODE_ERR  = 4'd8;

  // Lexer state
  logic [3:0]  mode_q, mode_d;
  logic [7:0]  held_q, held_d;
  logic        hv_q, hv_d;
  logic        fp_q, fp_d;
  logic        dot_q, dot_d;
  logic [2:0]  nlen_q, nlen_d;
  logic [47:0] npfx_q, npfx_d;
  logic        sp_q, sp_d;
  logic        sn_q, sn_d;

  // Result buffer
  slx_pkg::out_word_t buf_q [slx_pkg::MaxResults];
  slx_pkg::out_word_t res   [slx_pkg::MaxResults];
  logic [2:0] cnt_q;
  logic [2:0] n;

  logic accept, pop;
  logic [7:0] c, f, pc;
  logic is_al, is_dg, is_wd, pair;
  logic do_push, do_end, do_res, do_start;
  logic [2:0] kd;

  assign pop         = (cnt_q != 3'd0) && !out_stall_i;
  assign in_stall_o  = (cnt_q > 3'd1) || ((cnt_q == 3'd1) && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_word_o  = buf_q[0];

  // Kind of the open token
  function automatic logic [2:0] kind_of(logic [3:0] m);
    logic [2:0] k;
    unique case (m)
      MODE_NUM:  k = slx_pkg::KIND_NUM;
      MODE_NAME: k = slx_pkg::KIND_NAME;
      MODE_GLOB: k = slx_pkg::KIND_GLOB;
      default:   k = slx_pkg::KIND_STR;
    endcase
    return k;
  endfunction

  // Next lexer state and results for one character
  always_comb begin
    mode_d = mode_q; held_d = held_q; hv_d = hv_q; fp_d = fp_q; dot_d = dot_q;
    nlen_d = nlen_q; npfx_d = npfx_q; sp_d = sp_q; sn_d = sn_q;
    n = 3'd0;
    for (int i = 0; i < slx_pkg::MaxResults; i++) begin
      res[i] = slx_pkg::mk_word(slx_pkg::KIND_END, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0,
                                slx_pkg::KW_NONE);
    end
    c = in_word_i.char_code;
    f = held_q;
    is_al = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    is_dg = (c >= "0" && c <= "9");
    is_wd = is_al || is_dg || (c == "_");
    pair  = ((c == "=") && (f == "=" || f == "!" || f == "<" || f == ">")) ||
            ((c == "|") && (f == "|")) || ((c == "/") && (f == "/"));
    do_push = 1'b0; do_end = 1'b0; do_res = 1'b0; do_start = 1'b0;
    pc = c;
    kd = slx_pkg::KW_NONE;

    if (mode_d != MODE_ERR) begin
      if (c[7]) begin
        // high code: error in every mode outside the error mode
        if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_ERR, 8'd0, 8'd0,
                                                       1'b0, 1'b1, 1'b1, slx_pkg::KW_NONE);
        if (n < 3'd4) n = n + 3'd1;
        mode_d = MODE_ERR; hv_d = 1'b0; held_d = 8'd0; fp_d = 1'b1; dot_d = 1'b0;
        nlen_d = 3'd0; npfx_d = '0; sp_d = 1'b0; sn_d = 1'b0;
      end else begin
        unique case (mode_d)
          MODE_IDLE: do_start = 1'b1;
          MODE_NUM: begin
            if (is_dg) do_push = 1'b1;
            else if (c == "." && !dot_q) begin
              dot_d = 1'b1; do_push = 1'b1;
            end else if (c == "." || is_al || c == "_") begin
              if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_ERR, 8'd0, 8'd0,
                                                           1'b0, 1'b1, 1'b1, slx_pkg::KW_NONE);
              if (n < 3'd4) n = n + 3'd1;
              mode_d = MODE_ERR; hv_d = 1'b0; held_d = 8'd0; fp_d = 1'b1; dot_d = 1'b0;
              nlen_d = 3'd0; npfx_d = '0; sp_d = 1'b0; sn_d = 1'b0;
            end else begin
              do_end = 1'b1; do_start = 1'b1;
            end
          end
          MODE_NAME: begin
            if (is_wd) begin
              do_push = 1'b1;
              npfx_d = {npfx_q[39:0], c};
              if (nlen_q != 3'd7) nlen_d = nlen_q + 3'd1;
            end else begin
              do_end = 1'b1; do_start = 1'b1;
            end
          end
          MODE_GLOB: begin
            if (is_wd) do_push = 1'b1;
            else begin
              do_end = 1'b1; do_start = 1'b1;
            end
          end
          MODE_STR, MODE_ESC: begin
            if (c == 8'h0A) begin
              // raw or escaped newline inside a string
              if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_ERR, 8'd0, 8'd0,
                                                           1'b0, 1'b1, 1'b1, slx_pkg::KW_NONE);
              if (n < 3'd4) n = n + 3'd1;
              mode_d = MODE_ERR; hv_d = 1'b0; held_d = 8'd0; fp_d = 1'b1; dot_d = 1'b0;
              nlen_d = 3'd0; npfx_d = '0; sp_d = 1'b0; sn_d = 1'b0;
            end else if (mode_q == MODE_ESC) begin
              mode_d = MODE_STR; do_push = 1'b1;
              pc = (c == "n") ? 8'h0A : c;
            end else if (c == "\\") mode_d = MODE_ESC;
            else if (c == "\"") do_end = 1'b1;
            else do_push = 1'b1;
          end
          MODE_MARK: begin
            if (pair) begin
              held_d = 8'd0;
              if (f == "/") mode_d = MODE_CMT;
              else begin
                mode_d = MODE_IDLE;
                if (sp_d) begin
                  if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_SIGN,
                                                sn_d ? "-" : "+", 8'd0, 1'b1, 1'b1, 1'b1,
                                                slx_pkg::KW_NONE);
                  if (n < 3'd4) n = n + 3'd1;
                end
                sp_d = 1'b0; sn_d = 1'b0;
                if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_MARK, f, c, 1'b1,
                                                             1'b1, 1'b1, slx_pkg::KW_NONE);
                if (n < 3'd4) n = n + 3'd1;
              end
            end else begin
              do_res = 1'b1; do_start = 1'b1;
            end
          end
          MODE_CMT: if (c == 8'h0A) mode_d = MODE_IDLE;
          default: ;
        endcase

        // append a character to the open token
        if (do_push) begin
          if (hv_d) begin
            if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(kind_of(mode_d), held_d, 8'd0, 1'b1,
                                                         fp_d, 1'b0, slx_pkg::KW_NONE);
            if (n < 3'd4) n = n + 3'd1;
            fp_d = 1'b0;
          end
          held_d = pc; hv_d = 1'b1;
        end

        // close the open token
        if (do_end) begin
          kd = (mode_d == MODE_NAME) ? slx_pkg::kw_of(nlen_d, npfx_d) : slx_pkg::KW_NONE;
          if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(kind_of(mode_d), hv_d ? held_d : 8'd0,
                                                       8'd0, hv_d, hv_d ? fp_d : 1'b1, 1'b1, kd);
          if (n < 3'd4) n = n + 3'd1;
          hv_d = 1'b0; held_d = 8'd0; fp_d = 1'b1; dot_d = 1'b0;
          nlen_d = 3'd0; npfx_d = '0; mode_d = MODE_IDLE;
        end

        // settle a one-character mark
        if (do_res) begin
          held_d = 8'd0; mode_d = MODE_IDLE;
          if (f == "|") begin
            if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_ERR, 8'd0, 8'd0,
                                                         1'b0, 1'b1, 1'b1, slx_pkg::KW_NONE);
            if (n < 3'd4) n = n + 3'd1;
            mode_d = MODE_ERR; hv_d = 1'b0; fp_d = 1'b1; dot_d = 1'b0;
            nlen_d = 3'd0; npfx_d = '0; sp_d = 1'b0; sn_d = 1'b0;
          end else begin
            if (sp_d) begin
              if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_SIGN,
                                            sn_d ? "-" : "+", 8'd0, 1'b1, 1'b1, 1'b1,
                                            slx_pkg::KW_NONE);
              if (n < 3'd4) n = n + 3'd1;
            end
            sp_d = 1'b0; sn_d = 1'b0;
            if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_MARK, f, 8'd0, 1'b1,
                                                         1'b1, 1'b1, slx_pkg::KW_NONE);
            if (n < 3'd4) n = n + 3'd1;
          end
        end

        // start a new token from between tokens
        if (do_start && mode_d == MODE_IDLE) begin
          if (c == "+" || c == "-") begin
            if (sp_d) sn_d = sn_d ^ (c == "-");
            else begin
              sp_d = 1'b1; sn_d = (c == "-");
            end
          end else if (c == " " || c == 8'h0A) begin
            // blank: dropped
          end else if (c == "|" || c == "=" || c == "!" || c == "<" || c == ">" ||
                       c == "/") begin
            mode_d = MODE_MARK; held_d = c;
          end else if (is_wd || c == "&" || c == "\"" || c == "," || c == "." ||
                       c == "*" || c == "(" || c == ")" || c == "{" || c == "}" ||
                       c == "[" || c == "]" || c == ";") begin
            // every other accepted start releases a pending sign first
            if (sp_d) begin
              if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_SIGN,
                                            sn_d ? "-" : "+", 8'd0, 1'b1, 1'b1, 1'b1,
                                            slx_pkg::KW_NONE);
              if (n < 3'd4) n = n + 3'd1;
            end
            sp_d = 1'b0; sn_d = 1'b0;
            if (c == "&") begin
              mode_d = MODE_GLOB; fp_d = 1'b1;
            end else if (c == "\"") begin
              mode_d = MODE_STR; fp_d = 1'b1;
            end else if (is_wd) begin
              mode_d = is_dg ? MODE_NUM : MODE_NAME;
              fp_d = 1'b1; dot_d = 1'b0;
              if (!is_dg) begin
                npfx_d = {40'd0, c}; nlen_d = 3'd1;
              end
              if (hv_d) begin
                if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(kind_of(mode_d), held_d, 8'd0,
                                                             1'b1, fp_d, 1'b0,
                                                             slx_pkg::KW_NONE);
                if (n < 3'd4) n = n + 3'd1;
                fp_d = 1'b0;
              end
              held_d = c; hv_d = 1'b1;
            end else begin
              if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_MARK, c, 8'd0, 1'b1,
                                                           1'b1, 1'b1, slx_pkg::KW_NONE);
              if (n < 3'd4) n = n + 3'd1;
            end
          end else begin
            if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_ERR, 8'd0, 8'd0,
                                                         1'b0, 1'b1, 1'b1, slx_pkg::KW_NONE);
            if (n < 3'd4) n = n + 3'd1;
            mode_d = MODE_ERR; hv_d = 1'b0; held_d = 8'd0; fp_d = 1'b1; dot_d = 1'b0;
            nlen_d = 3'd0; npfx_d = '0; sp_d = 1'b0; sn_d = 1'b0;
          end
        end
      end
    end

    // end of text: close what is open, release the sign, then the end word
    if (in_word_i.last) begin
      if (mode_d == MODE_NUM || mode_d == MODE_NAME || mode_d == MODE_GLOB ||
          mode_d == MODE_STR || mode_d == MODE_ESC) begin
        kd = (mode_d == MODE_NAME) ? slx_pkg::kw_of(nlen_d, npfx_d) : slx_pkg::KW_NONE;
        if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(kind_of(mode_d), hv_d ? held_d : 8'd0,
                                                     8'd0, hv_d, hv_d ? fp_d : 1'b1, 1'b1, kd);
        if (n < 3'd4) n = n + 3'd1;
        mode_d = MODE_IDLE;
      end else if (mode_d == MODE_MARK) begin
        if (held_d == "|") begin
          if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_ERR, 8'd0, 8'd0,
                                                       1'b0, 1'b1, 1'b1, slx_pkg::KW_NONE);
          if (n < 3'd4) n = n + 3'd1;
          mode_d = MODE_ERR;
        end else begin
          if (sp_d) begin
            if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_SIGN,
                                          sn_d ? "-" : "+", 8'd0, 1'b1, 1'b1, 1'b1,
                                          slx_pkg::KW_NONE);
            if (n < 3'd4) n = n + 3'd1;
          end
          sp_d = 1'b0;
          if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_MARK, held_d, 8'd0,
                                                       1'b1, 1'b1, 1'b1, slx_pkg::KW_NONE);
          if (n < 3'd4) n = n + 3'd1;
          mode_d = MODE_IDLE;
        end
      end
      if (mode_d != MODE_ERR && sp_d) begin
        if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_SIGN, sn_d ? "-" : "+",
                                                     8'd0, 1'b1, 1'b1, 1'b1,
                                                     slx_pkg::KW_NONE);
        if (n < 3'd4) n = n + 3'd1;
      end
      if (n < 3'd4) res[n[1:0]] = slx_pkg::mk_word(slx_pkg::KIND_END, 8'd0, 8'd0, 1'b0,
                                                   1'b1, 1'b1, slx_pkg::KW_NONE);
      if (n < 3'd4) n = n + 3'd1;
      mode_d = MODE_IDLE; held_d = 8'd0; hv_d = 1'b0; fp_d = 1'b1; dot_d = 1'b0;
      nlen_d = 3'd0; npfx_d = '0; sp_d = 1'b0; sn_d = 1'b0;
    end

    // mark the final result of this character
    if (n != 3'd0) res[n[1:0] - 2'd1].run_last = 1'b1;
  end

  // Lexer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      held_q <= 8'd0;
      hv_q   <= 1'b0;
      fp_q   <= 1'b1;
      dot_q  <= 1'b0;
      nlen_q <= 3'd0;
      npfx_q <= '0;
      sp_q   <= 1'b0;
      sn_q   <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
      hv_q   <= hv_d;
      fp_q   <= fp_d;
      dot_q  <= dot_d;
      nlen_q <= nlen_d;
      npfx_q <= npfx_d;
      sp_q   <= sp_d;
      sn_q   <= sn_d;
    end
  end

  // Result buffer count: loaded only when empty or emptying this cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (accept) begin
      cnt_q <= n;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  // Result buffer payload: loaded on each character taken, else shifted down on each word taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < slx_pkg::MaxResults; i++) buf_q[i] <= res[i];
    end else if (pop) begin
      for (int i = 0; i < slx_pkg::MaxResults - 1; i++) buf_q[i] <= buf_q[i + 1];
    end
  end

endmodule

/* hdl/slx_checker.sv */
// Port-level checks for the script lexer, bound to the top level
module slx_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_stall_o,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  slx_pkg::out_word_t out_word_o
);

  // a stalled output word stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word dropped or changed");

  // no new character while the buffered word is held by the receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input open while output stalled");

  // the end word is always the final result of its character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == slx_pkg::KIND_END |-> out_word_o.run_last)
    else $error("end word without run_last");

  // error words are bare single-item tokens
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == slx_pkg::KIND_ERR |->
      out_word_o.token_first && out_word_o.token_last && !out_word_o.has_char)
    else $error("malformed error word");

endmodule

bind script_lexer_with_sign_folding slx_checker u_slx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

/* sim/tb_script_lexer_with_sign_folding.sv */
// Testbench for the streaming script lexer: directed and random character streams
`timescale 1ns / 100ps

module tb_script_lexer_with_sign_folding;
  import slx_pkg::*;

  // Lexer modes of the predictor
  typedef enum logic [3:0] {
    LM_IDLE, LM_NUM, LM_STR, LM_ESC, LM_NAME, LM_GLOB, LM_MARK, LM_CMT, LM_ERR
  } lex_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  script_lexer_with_sign_folding uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  lex_mode_e   p_mode;
  logic [7:0]  p_held;
  logic        p_held_v, p_first, p_dot, p_sign_p, p_sign_n;
  logic [2:0]  p_len;
  logic [47:0] p_pfx;

  out_word_t   token_q[$];
  out_word_t   step_buf[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off = 0;

  task automatic lex_reset();
    p_mode = LM_IDLE; p_held = '0; p_held_v = 0; p_first = 1; p_dot = 0;
    p_len = '0; p_pfx = '0; p_sign_p = 0; p_sign_n = 0;
  endtask

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  task automatic put(logic [2:0] k, logic [7:0] c, logic [7:0] c2, logic h,
                     logic f, logic l, logic [2:0] kw);
    out_word_t w;
    w = '{kind: k, char_out: c, second_char: c2, has_char: h, token_first: f,
          token_last: l, keyword: kw, run_last: 1'b0};
    step_buf.insert(step_buf.size(), w);
  endtask

  function automatic logic [2:0] tok_kind();
    if (p_mode == LM_NUM) return KIND_NUM;
    if (p_mode == LM_NAME) return KIND_NAME;
    if (p_mode == LM_GLOB) return KIND_GLOB;
    return KIND_STR;
  endfunction

  function automatic logic [2:0] keyword_match();
    if (p_len == 3 && p_pfx == 48'h646566) return KW_DEF;
    if (p_len == 6 && p_pfx == 48'h72657475726E) return KW_RETURN;
    if (p_len == 2 && p_pfx == 48'h6966) return KW_IF;
    if (p_len == 4 && p_pfx == 48'h656C7365) return KW_ELSE;
    if (p_len == 5 && p_pfx == 48'h7768696C65) return KW_WHILE;
    if (p_len == 4 && p_pfx == 48'h6E756C6C) return KW_NULL;
    return KW_NONE;
  endfunction

  task automatic push_tok(logic [7:0] c);
    if (p_held_v) begin
      put(tok_kind(), p_held, 0, 1, p_first, 0, KW_NONE);
      p_first = 0;
    end
    p_held = c; p_held_v = 1;
  endtask

  task automatic close_tok();
    logic [2:0] kw;
    kw = (p_mode == LM_NAME) ? keyword_match() : KW_NONE;
    if (p_held_v) put(tok_kind(), p_held, 0, 1, p_first, 1, kw);
    else put(tok_kind(), 0, 0, 0, 1, 1, kw);
    p_held_v = 0; p_held = 0; p_first = 1; p_dot = 0; p_len = 0; p_pfx = 0;
    p_mode = LM_IDLE;
  endtask

  task automatic flush_sign();
    if (p_sign_p) put(KIND_SIGN, p_sign_n ? "-" : "+", 0, 1, 1, 1, KW_NONE);
    p_sign_p = 0; p_sign_n = 0;
  endtask

  task automatic enter_error();
    put(KIND_ERR, 0, 0, 0, 1, 1, KW_NONE);
    p_mode = LM_ERR;
    p_held_v = 0; p_held = 0; p_first = 1; p_dot = 0; p_len = 0; p_pfx = 0;
    p_sign_p = 0; p_sign_n = 0;
  endtask

  task automatic begin_tok(logic [7:0] c);
    if (c == "+" || c == "-") begin
      if (p_sign_p) p_sign_n = p_sign_n ^ (c == "-");
      else begin p_sign_p = 1; p_sign_n = (c == "-"); end
    end else if (c == " " || c == 8'h0A) begin
    end else if (c == "&") begin
      flush_sign(); p_mode = LM_GLOB; p_first = 1;
    end else if (is_alpha(c) || c == "_") begin
      flush_sign(); p_mode = LM_NAME; p_first = 1;
      push_tok(c); p_pfx = {40'd0, c}; p_len = 1;
    end else if (is_digit(c)) begin
      flush_sign(); p_mode = LM_NUM; p_first = 1; p_dot = 0; push_tok(c);
    end else if (c == 8'h22) begin
      flush_sign(); p_mode = LM_STR; p_first = 1;
    end else if (c == "|" || c == "=" || c == "!" || c == "<" || c == ">" || c == "/") begin
      p_mode = LM_MARK; p_held = c;
    end else if (c == "," || c == "." || c == "*" || c == "(" || c == ")" || c == "{" ||
                 c == "}" || c == "[" || c == "]" || c == ";") begin
      flush_sign(); put(KIND_MARK, c, 0, 1, 1, 1, KW_NONE);
    end else begin
      enter_error();
    end
  endtask

  task automatic single_mark();
    logic [7:0] f;
    f = p_held; p_held = 0; p_mode = LM_IDLE;
    if (f == "|") enter_error();
    else begin
      flush_sign(); put(KIND_MARK, f, 0, 1, 1, 1, KW_NONE);
    end
  endtask

  task automatic lex_char(logic [7:0] c);
    logic [7:0] f;
    bit pair;
    if (c >= 128) begin enter_error(); return; end
    case (p_mode)
      LM_IDLE: begin_tok(c);
      LM_NUM: begin
        if (is_digit(c)) push_tok(c);
        else if (c == ".") begin
          if (p_dot) enter_error();
          else begin p_dot = 1; push_tok(c); end
        end else if (is_alpha(c) || c == "_") enter_error();
        else begin close_tok(); begin_tok(c); end
      end
      LM_NAME: begin
        if (is_word(c)) begin
          push_tok(c); p_pfx = {p_pfx[39:0], c};
          if (p_len < 7) p_len++;
        end else begin close_tok(); begin_tok(c); end
      end
      LM_GLOB: begin
        if (is_word(c)) push_tok(c);
        else begin close_tok(); begin_tok(c); end
      end
      LM_STR: begin
        if (c == 8'h0A) enter_error();
        else if (c == 8'h5C) p_mode = LM_ESC;
        else if (c == 8'h22) close_tok();
        else push_tok(c);
      end
      LM_ESC: begin
        if (c == 8'h0A) enter_error();
        else begin p_mode = LM_STR; push_tok(c == "n" ? 8'h0A : c); end
      end
      LM_MARK: begin
        f = p_held;
        pair = (c == "=" && (f == "=" || f == "!" || f == "<" || f == ">")) ||
               (c == "|" && f == "|") || (c == "/" && f == "/");
        if (pair) begin
          p_held = 0;
          if (f == "/") p_mode = LM_CMT;
          else begin
            p_mode = LM_IDLE; flush_sign(); put(KIND_MARK, f, c, 1, 1, 1, KW_NONE);
          end
        end else begin
          single_mark();
          if (p_mode == LM_IDLE) begin_tok(c);
        end
      end
      LM_CMT: if (c == 8'h0A) p_mode = LM_IDLE;
      default: ;
    endcase
  endtask

  // Work out the results of one character and queue them
  task automatic predict_tokens(in_word_t w);
    step_buf.delete();
    if (p_mode != LM_ERR) lex_char(w.char_code);
    if (w.last) begin
      if (p_mode inside {LM_NUM, LM_NAME, LM_GLOB, LM_STR, LM_ESC}) close_tok();
      else if (p_mode == LM_MARK) single_mark();
      if (p_mode != LM_ERR) flush_sign();
      put(KIND_END, 0, 0, 0, 1, 1, KW_NONE);
      lex_reset();
    end
    if (step_buf.size() > 0) step_buf[step_buf.size() - 1].run_last = 1'b1;
    foreach (step_buf[i]) token_q.insert(token_q.size(), step_buf[i]);
  endtask

  // Send one character word, waiting for acceptance; valid drops only while idling
  task automatic send_char(logic [7:0] c, logic l);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{char_code: c, last: l};
    do @(posedge clk_i); while (in_stall_o);
    predict_tokens('{char_code: c, last: l});
  endtask

  task automatic send_text(string s, bit close);
    for (int i = 0; i < s.len(); i++) send_char(s[i], close && i == s.len() - 1);
  endtask

  // Stop offering words and wait for every expected result
  task automatic drain_wait();
    int n;
    n = 0;
    in_valid_i <= 1'b0;
    while (token_q.size() > 0 && n < 200000) begin @(posedge clk_i); n++; end
  endtask

  // Receiver stall generator
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off <= hold_off - 1;
    end else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (token_q.size() == 0) begin
        $error("unexpected result word %h", out_word_o); errors++;
      end else begin
        e = token_q.pop_front();
        if (out_word_o.kind != e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_word_o.kind); errors++; end
        if (out_word_o.char_out != e.char_out) begin
          $error("char_out exp %h got %h", e.char_out, out_word_o.char_out); errors++; end
        if (out_word_o.second_char != e.second_char) begin
          $error("second_char exp %h got %h", e.second_char, out_word_o.second_char);
          errors++; end
        if (out_word_o.has_char != e.has_char) begin
          $error("has_char exp %0d got %0d", e.has_char, out_word_o.has_char); errors++; end
        if (out_word_o.token_first != e.token_first) begin
          $error("token_first exp %0d got %0d", e.token_first, out_word_o.token_first);
          errors++; end
        if (out_word_o.token_last != e.token_last) begin
          $error("token_last exp %0d got %0d", e.token_last, out_word_o.token_last);
          errors++; end
        if (out_word_o.keyword != e.keyword) begin
          $error("keyword exp %0d got %0d", e.keyword, out_word_o.keyword); errors++; end
        if (out_word_o.run_last != e.run_last) begin
          $error("run_last exp %0d got %0d", e.run_last, out_word_o.run_last); errors++; end
      end
    end
  end

  task automatic test_directed();
    send_text("def return if else while null iff x_1 abcdefghij", 1);
    send_text("12.5 3.4.5", 1);
    send_text("7a", 1);
    send_text("\"a\\nb\\\"\" \"\" & && &g_9", 1);
    send_text("|| == != <= >= = < > ! / , . * ( ) { } [ ] ;", 1);
    send_text("-+- 5 + // note -\n- x", 1);
    send_text("a | b", 1);
    send_text("\"x\ny", 1);
    send_text("\"ab\\", 1);
    send_text("--", 1);
    send_text("<", 1);
    send_text("# x", 1);
    send_char(8'hFF, 1'b0); send_char(8'h80, 1'b1);
    send_char(8'h00, 1'b1);
  endtask

  // Random character drawn mostly from the language's alphabet
  function automatic logic [7:0] rand_char();
    string pool;
    int r;
    pool = "abcdefilnorstuwhz_AZ0123456789.+-&\" \\\n|=!<>/,*(){}[];";
    r = $urandom_range(99);
    if (r < 4) return 8'($urandom_range(255));
    if (r < 12) return 8'($urandom_range(127));
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_char(rand_char(), $urandom_range(29) == 0);
    send_char(" ", 1'b1);
  endtask

  task automatic test_back_pressure();
    fork
      hold_off = 300;
      send_text("abc 12 \"s\" == + x", 1);
    join
    drain_wait();
    send_idle_pct = 0;
    send_text("-x", 1);
  endtask

  initial begin
    lex_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(45);
    send_idle_pct = 63; recv_stall_pct = 0;
    test_random(45);
    send_idle_pct = 0; recv_stall_pct = 63;
    test_random(45);
    send_idle_pct = 25; recv_stall_pct = 25;
    test_random(45);
    drain_wait();
    send_idle_pct = 0; recv_stall_pct = 0;
    test_back_pressure();
    drain_wait();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && token_q.size() == 0) $display("** script_lexer_with_sign_folding: PASSED **");
    else $display("** script_lexer_with_sign_folding: FAILED **");
    $finish;
  end

  initial begin
    #5ms;
    $display("** script_lexer_with_sign_folding: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
hdl/slx_pkg.sv
hdl/script_lexer_with_sign_folding.sv
hdl/slx_checker.sv
sim/tb_script_lexer_with_sign_folding.sv
